@@ rtl/idll_pkg.sv @@
// Shared constants, types and helpers for the indexed doubly linked list.
`default_nettype none
package idll_pkg;

   localparam int CAPACITY = 64;
   localparam int ID_W     = 7;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OP_W     = 3;

   typedef enum logic [OP_W-1:0] {
      OP_START     = 3'd0,
      OP_INS_LEFT  = 3'd1,
      OP_INS_RIGHT = 3'd2,
      OP_REMOVE    = 3'd3,
      OP_DUMP      = 3'd4
   } op_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             prev_we;
      logic [IDX_W-1:0] prev_waddr;
      logic [ID_W-1:0]  prev_wdata;
      logic             next_we;
      logic [IDX_W-1:0] next_waddr;
      logic [ID_W-1:0]  next_wdata;
   } link_req_type;

   typedef struct packed {
      logic [ID_W-1:0] prev_id;
      logic [ID_W-1:0] next_id;
   } link_rsp_type;

   function automatic logic id_ok(input logic [ID_W-1:0] id);
      return (id != '0) && (id <= ID_W'(CAPACITY));
   endfunction

   function automatic logic [IDX_W-1:0] to_addr(input logic [ID_W-1:0] id);
      logic [ID_W-1:0] dec;
      dec = id - ID_W'(1);
      return dec[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/idll_link_mem.sv @@
// Previous and next link tables: two synchronous RAMs sharing one read address.
`default_nettype none
module idll_link_mem (
   input  wire logic                  clock,
   input  wire idll_pkg::link_req_type req,
   output idll_pkg::link_rsp_type     rsp
);

   logic [idll_pkg::ID_W-1:0] prev_mem [idll_pkg::CAPACITY];
   logic [idll_pkg::ID_W-1:0] next_mem [idll_pkg::CAPACITY];
   logic [idll_pkg::ID_W-1:0] prev_rd_ff;
   logic [idll_pkg::ID_W-1:0] next_rd_ff;

   always_ff @(posedge clock) begin
      if (req.prev_we) begin
         prev_mem[req.prev_waddr] <= req.prev_wdata;
      end
      if (req.next_we) begin
         next_mem[req.next_waddr] <= req.next_wdata;
      end
      if (req.rd_en) begin
         prev_rd_ff <= prev_mem[req.rd_addr];
         next_rd_ff <= next_mem[req.rd_addr];
      end
   end

   assign rsp.prev_id = prev_rd_ff;
   assign rsp.next_id = next_rd_ff;

endmodule
`default_nettype wire

@@ rtl/indexed_doubly_linked_list.sv @@
// Top level: operation sequencer, presence flags, head/tail and dump output.
// Node ids 1..CAPACITY are kept in list order in two link RAMs (registered
// read). One transaction is worked on at a time: start and ignored operations
// finish in the idle state, remove goes through a link read and a neighbor
// update, insert through a link read, the new node links and the neighbor
// links. Dump first reads the head's link and then delivers one node per
// cycle while rsp_ready is high; an empty list yields a single node_id 0
// result. The last result sits in the output register while the next
// transaction is accepted.
`default_nettype none
module indexed_doubly_linked_list (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [idll_pkg::OP_W-1:0]   req_operation,
   input  wire logic [idll_pkg::ID_W-1:0]   req_node,
   input  wire logic [idll_pkg::ID_W-1:0]   req_anchor,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [idll_pkg::ID_W-1:0]        rsp_node_id,
   output logic                             rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LINK,
      ST_FIX,
      ST_WALK,
      ST_EMPTY
   } state_type;

   state_type                       state_ff, state_in;
   idll_pkg::op_type                op_ff, op_in;
   logic [idll_pkg::ID_W-1:0]       node_ff, node_in;
   logic [idll_pkg::ID_W-1:0]       anchor_ff, anchor_in;
   logic [idll_pkg::CAPACITY-1:0]   present_ff, present_in;
   logic [idll_pkg::ID_W-1:0]       head_ff, head_in;
   logic [idll_pkg::ID_W-1:0]       tail_ff, tail_in;
   logic [idll_pkg::ID_W-1:0]       cursor_ff, cursor_in;
   logic [idll_pkg::IDX_W-1:0]      cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [idll_pkg::ID_W-1:0]       rsp_node_id_ff, rsp_node_id_in;
   logic                            rsp_last_ff, rsp_last_in;

   idll_pkg::link_req_type          mem_req;
   idll_pkg::link_rsp_type          mem_rsp;

   logic                            slot_free;
   logic                            req_node_present;
   logic                            req_anchor_present;
   logic                            walk_last;

   idll_link_mem u_link_mem (
      .clock (clock),
      .req   (mem_req),
      .rsp   (mem_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign req_node_present   = idll_pkg::id_ok(req_node) &&
                               present_ff[idll_pkg::to_addr(req_node)];
   assign req_anchor_present = idll_pkg::id_ok(req_anchor) &&
                               present_ff[idll_pkg::to_addr(req_anchor)];
   assign walk_last = !idll_pkg::id_ok(mem_rsp.next_id) ||
                      (cnt_ff == idll_pkg::IDX_W'(idll_pkg::CAPACITY - 1));

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      node_in        = node_ff;
      anchor_in      = anchor_ff;
      present_in     = present_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      cursor_in      = cursor_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_node_id_in = rsp_node_id_ff;
      rsp_last_in    = rsp_last_ff;
      mem_req        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = idll_pkg::op_type'(req_operation);
               node_in   = req_node;
               anchor_in = req_anchor;
               case (idll_pkg::op_type'(req_operation))
                  idll_pkg::OP_START: begin
                     present_in = '0;
                     if (idll_pkg::id_ok(req_node)) begin
                        present_in[idll_pkg::to_addr(req_node)] = 1'b1;
                        head_in            = req_node;
                        tail_in            = req_node;
                        mem_req.prev_we    = 1'b1;
                        mem_req.prev_waddr = idll_pkg::to_addr(req_node);
                        mem_req.prev_wdata = '0;
                        mem_req.next_we    = 1'b1;
                        mem_req.next_waddr = idll_pkg::to_addr(req_node);
                        mem_req.next_wdata = '0;
                     end else begin
                        head_in = '0;
                        tail_in = '0;
                     end
                  end
                  idll_pkg::OP_INS_LEFT, idll_pkg::OP_INS_RIGHT: begin
                     if (idll_pkg::id_ok(req_node) && !req_node_present &&
                         req_anchor_present) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idll_pkg::to_addr(req_anchor);
                        state_in        = ST_LINK;
                     end
                  end
                  idll_pkg::OP_REMOVE: begin
                     if (req_node_present) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idll_pkg::to_addr(req_node);
                        state_in        = ST_LINK;
                     end
                  end
                  idll_pkg::OP_DUMP: begin
                     if (idll_pkg::id_ok(head_ff)) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idll_pkg::to_addr(head_ff);
                        cursor_in       = head_ff;
                        cnt_in          = '0;
                        state_in        = ST_WALK;
                     end else begin
                        state_in = ST_EMPTY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_LINK: begin
            state_in = ST_IDLE;
            case (op_ff)
               idll_pkg::OP_INS_LEFT: begin
                  present_in[idll_pkg::to_addr(node_ff)] = 1'b1;
                  mem_req.prev_we    = 1'b1;
                  mem_req.prev_waddr = idll_pkg::to_addr(node_ff);
                  mem_req.prev_wdata = mem_rsp.prev_id;
                  mem_req.next_we    = 1'b1;
                  mem_req.next_waddr = idll_pkg::to_addr(node_ff);
                  mem_req.next_wdata = anchor_ff;
                  state_in           = ST_FIX;
               end
               idll_pkg::OP_INS_RIGHT: begin
                  present_in[idll_pkg::to_addr(node_ff)] = 1'b1;
                  mem_req.prev_we    = 1'b1;
                  mem_req.prev_waddr = idll_pkg::to_addr(node_ff);
                  mem_req.prev_wdata = anchor_ff;
                  mem_req.next_we    = 1'b1;
                  mem_req.next_waddr = idll_pkg::to_addr(node_ff);
                  mem_req.next_wdata = mem_rsp.next_id;
                  state_in           = ST_FIX;
               end
               idll_pkg::OP_REMOVE: begin
                  present_in[idll_pkg::to_addr(node_ff)] = 1'b0;
                  if (idll_pkg::id_ok(mem_rsp.prev_id)) begin
                     mem_req.next_we    = 1'b1;
                     mem_req.next_waddr = idll_pkg::to_addr(mem_rsp.prev_id);
                     mem_req.next_wdata = mem_rsp.next_id;
                  end else begin
                     head_in = mem_rsp.next_id;
                  end
                  if (idll_pkg::id_ok(mem_rsp.next_id)) begin
                     mem_req.prev_we    = 1'b1;
                     mem_req.prev_waddr = idll_pkg::to_addr(mem_rsp.next_id);
                     mem_req.prev_wdata = mem_rsp.prev_id;
                  end else begin
                     tail_in = mem_rsp.prev_id;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_FIX: begin
            state_in = ST_IDLE;
            case (op_ff)
               idll_pkg::OP_INS_LEFT: begin
                  mem_req.prev_we    = 1'b1;
                  mem_req.prev_waddr = idll_pkg::to_addr(anchor_ff);
                  mem_req.prev_wdata = node_ff;
                  if (idll_pkg::id_ok(mem_rsp.prev_id)) begin
                     mem_req.next_we    = 1'b1;
                     mem_req.next_waddr = idll_pkg::to_addr(mem_rsp.prev_id);
                     mem_req.next_wdata = node_ff;
                  end else begin
                     head_in = node_ff;
                  end
               end
               idll_pkg::OP_INS_RIGHT: begin
                  mem_req.next_we    = 1'b1;
                  mem_req.next_waddr = idll_pkg::to_addr(anchor_ff);
                  mem_req.next_wdata = node_ff;
                  if (idll_pkg::id_ok(mem_rsp.next_id)) begin
                     mem_req.prev_we    = 1'b1;
                     mem_req.prev_waddr = idll_pkg::to_addr(mem_rsp.next_id);
                     mem_req.prev_wdata = node_ff;
                  end else begin
                     tail_in = node_ff;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_WALK: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_node_id_in = cursor_ff;
               rsp_last_in    = walk_last;
               if (walk_last) begin
                  cursor_in = '0;
                  state_in  = ST_IDLE;
               end else begin
                  cursor_in       = mem_rsp.next_id;
                  cnt_in          = cnt_ff + idll_pkg::IDX_W'(1);
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idll_pkg::to_addr(mem_rsp.next_id);
               end
            end
         end

         ST_EMPTY: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_node_id_in = '0;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         cursor_ff    <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cursor_ff    <= cursor_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      node_ff        <= node_in;
      anchor_ff      <= anchor_in;
      rsp_node_id_ff <= rsp_node_id_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_node_id = rsp_node_id_ff;
   assign rsp_last    = rsp_last_ff;

`ifndef SYNTHESIS
   a_head_tail_pair: assert property (@(posedge clock) disable iff (reset)
      (head_ff == '0) == (tail_ff == '0))
      else $error("head and tail disagree on empty list");

   a_head_present: assert property (@(posedge clock) disable iff (reset)
      (head_ff != '0) |-> (idll_pkg::id_ok(head_ff) &&
                           present_ff[idll_pkg::to_addr(head_ff)]))
      else $error("head node not present");

   a_walk_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (idll_pkg::id_ok(cursor_ff) &&
                                 present_ff[idll_pkg::to_addr(cursor_ff)]))
      else $error("dump cursor on absent node");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WALK ||
                               $past(state_ff) == ST_EMPTY))
      else $error("result raised outside dump");
`endif

endmodule
`default_nettype wire
